[hw/rtl/cgrm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_pkg
// shared types, constants and datapath helpers of the cartesian grid rank mapper
// ----------------------------------------------------------------------------
package cgrm_pkg;

  localparam int MAX_DIMS   = 4;
  localparam int DIM_IDX_W  = $clog2(MAX_DIMS);
  localparam int RANK_W     = 32;
  localparam int SIZE_W     = 9;
  localparam int COORD_W    = 8;
  localparam int NDIMS_W    = 3;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_STAGES = RANK_W / DIV_STEPS;
  localparam int CHAIN_LEN  = MAX_DIMS * DIV_STAGES;
  localparam int COMP_LAT   = MAX_DIMS - 1;

  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(256);

  // operation codes
  typedef enum logic [1:0] {
    OP_RANK_OF_COORDS = 2'd0,
    OP_COORDS_OF_RANK = 2'd1,
    OP_SHIFT          = 2'd2,
    OP_RESERVED       = 2'd3
  } op_t;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_ARG = 2'd1;
  localparam logic [1:0] ST_BAD_DIM = 2'd2;

  // register indexes
  localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
  localparam logic [2:0] REG_DIM_SIZE_0 = 3'd1;
  localparam logic [2:0] REG_DIM_SIZE_1 = 3'd2;
  localparam logic [2:0] REG_DIM_SIZE_2 = 3'd3;
  localparam logic [2:0] REG_DIM_SIZE_3 = 3'd4;
  localparam logic [2:0] REG_PERIODIC   = 3'd5;
  localparam logic [2:0] REG_OWN_RANK   = 3'd6;

  typedef logic [MAX_DIMS-1:0][COORD_W-1:0] coord_vec_t;
  typedef logic [MAX_DIMS-1:0][SIZE_W-1:0]  size_vec_t;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [RANK_W-1:0]  work;
    logic [SIZE_W-1:0]  divisor;
  } div_work_t;

  typedef struct packed {
    logic                             valid;
    op_t                              op;
    logic                             bad_coord;
    logic [MAX_DIMS-1:0]              neg;
    logic [MAX_DIMS-1:0][RANK_W-1:0]  mag;
    logic [DIM_IDX_W-1:0]             shift_dim;
    logic [RANK_W-1:0]                disp;
    logic [COORD_W-1:0]               disp_res;
    coord_vec_t                       res;
  } ctx_t;

  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [1:0] status;
    logic       src_none;
    logic       dst_none;
    coord_vec_t coords;
  } post_t;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] raw);
    if (raw == '0) return SIZE_W'(1);
    if (raw > MAX_SIZE) return MAX_SIZE;
    return raw;
  endfunction

  // restoring division, a few quotient bits per call
  function automatic div_work_t div_steps(div_work_t w);
    logic [SIZE_W-1:0] t;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {w.rem, w.work[RANK_W-1]};
      w.work = {w.work[RANK_W-2:0], 1'b0};
      if (t >= w.divisor) begin
        t = t - w.divisor;
        w.work[0] = 1'b1;
      end
      w.rem = t[COORD_W-1:0];
    end
    return w;
  endfunction

  // true non-negative residue from the residue of the magnitude
  function automatic logic [COORD_W-1:0] wrap_res(logic [COORD_W-1:0] rem, logic neg,
                                                  logic [SIZE_W-1:0] e);
    logic [SIZE_W-1:0] diff;
    diff = e - {1'b0, rem};
    if (neg && rem != '0) return diff[COORD_W-1:0];
    return rem;
  endfunction

  function automatic logic [RANK_W-1:0] mac_step(logic [RANK_W-1:0] acc,
                                                 logic [SIZE_W-1:0] e,
                                                 logic [COORD_W-1:0] p);
    logic [RANK_W+SIZE_W-1:0] full;
    full = (RANK_W+SIZE_W)'(acc) * (RANK_W+SIZE_W)'(e) + (RANK_W+SIZE_W)'(p);
    return full[RANK_W-1:0];
  endfunction

endpackage

[hw/rtl/cgrm_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_divider
// pipelined rank by dimension size divider, quotient and remainder
// ----------------------------------------------------------------------------
module cgrm_divider import cgrm_pkg::*; (
  input  logic                clk,
  input  logic [RANK_W-1:0]   dividend,
  input  logic [SIZE_W-1:0]   divisor,
  output logic [RANK_W-1:0]   quotient,
  output logic [COORD_W-1:0]  remainder
);

  div_work_t stage_q [DIV_STAGES];

  always_ff @(posedge clk) begin
    stage_q[0] <= div_steps('{rem: '0, work: dividend, divisor: divisor});
    for (int s = 1; s < DIV_STAGES; s++) begin
      stage_q[s] <= div_steps(stage_q[s-1]);
    end
  end

  assign quotient  = stage_q[DIV_STAGES-1].work;
  assign remainder = stage_q[DIV_STAGES-1].rem;

endmodule

[hw/rtl/cgrm_compose.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgrm_compose
// pipelined mixed-radix composition of coordinates into a rank
// ----------------------------------------------------------------------------
module cgrm_compose import cgrm_pkg::*; (
  input  logic              clk,
  input  coord_vec_t        coords,
  input  size_vec_t         sizes,
  output logic [RANK_W-1:0] rank
);

  logic [RANK_W-1:0] acc_q [COMP_LAT];
  coord_vec_t        crd_q [COMP_LAT-1];

  always_ff @(posedge clk) begin
    acc_q[0] <= mac_step(RANK_W'(coords[0]), sizes[1], coords[1]);
    crd_q[0] <= coords;
  end

  for (genvar s = 1; s < COMP_LAT; s++) begin : g_stage
    always_ff @(posedge clk) begin
      acc_q[s] <= mac_step(acc_q[s-1], sizes[s+1], crd_q[s-1][s+1]);
    end
    if (s < COMP_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        crd_q[s] <= crd_q[s-1];
      end
    end
  end

  assign rank = acc_q[COMP_LAT-1];

endmodule

[hw/rtl/cartesian_grid_rank_mapper_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_grid_rank_mapper_core
// rank and coordinate mapping on a cartesian grid of up to four dimensions
// ----------------------------------------------------------------------------
// usage
// - query beat: taken on a clock edge with start high and busy low; busy
//   stays low, so a new query can go in on every cycle
// - result beat: done is high for one cycle with the result ports valid;
//   the receiver has no way to hold results off and none are needed
// - every operation takes the same path through the pipeline; throughput
//   one query per cycle
// - pipeline: a capture register, then the division chain of four 32 by 9 bit
//   dividers in series (4 stages each, 8 quotient bits a stage) for the
//   mixed-radix decomposition, then a status stage, the 3-stage
//   multiply-accumulate composition and the output register
// - config beat: cfg_valid with cfg_ready (always high) writes cfg_data to
//   register cfg_index; write only while no query is in flight
// - reset (rst, synchronous) empties the pipeline and sets the registers to
//   no dimensions, all sizes one, nothing periodic, own rank zero
// ----------------------------------------------------------------------------
module cartesian_grid_rank_mapper_core import cgrm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [31:0]        rank_in,
  input  logic signed [31:0] coord_in_0,
  input  logic signed [31:0] coord_in_1,
  input  logic signed [31:0] coord_in_2,
  input  logic signed [31:0] coord_in_3,
  input  logic [1:0]         shift_dim,
  input  logic signed [31:0] displacement,
  output logic               done,
  output logic [1:0]         status,
  output logic [31:0]        rank_out,
  output logic [7:0]         coord_out_0,
  output logic [7:0]         coord_out_1,
  output logic [7:0]         coord_out_2,
  output logic [7:0]         coord_out_3,
  output logic [31:0]        source_rank,
  output logic [31:0]        dest_rank,
  output logic               source_none,
  output logic               dest_none,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // edges from the accepting edge to the edge that takes the result beat
  localparam int LATENCY = CHAIN_LEN + COMP_LAT + 3;

  // configuration registers
  logic [NDIMS_W-1:0]  num_dims_q;
  size_vec_t           dim_size_q;
  logic [MAX_DIMS-1:0] periodic_q;
  logic [RANK_W-1:0]   own_rank_q;

  logic [NDIMS_W-1:0]  nd_eff;
  size_vec_t           eff;

  // pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims_q <= '0;
      for (int i = 0; i < MAX_DIMS; i++) dim_size_q[i] <= SIZE_W'(1);
      periodic_q <= '0;
      own_rank_q <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NUM_DIMS:   num_dims_q    <= cfg_data[NDIMS_W-1:0];
        REG_DIM_SIZE_0: dim_size_q[0] <= cfg_data[SIZE_W-1:0];
        REG_DIM_SIZE_1: dim_size_q[1] <= cfg_data[SIZE_W-1:0];
        REG_DIM_SIZE_2: dim_size_q[2] <= cfg_data[SIZE_W-1:0];
        REG_DIM_SIZE_3: dim_size_q[3] <= cfg_data[SIZE_W-1:0];
        REG_PERIODIC:   periodic_q    <= cfg_data[MAX_DIMS-1:0];
        REG_OWN_RANK:   own_rank_q    <= cfg_data[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // unused dimensions act as size one at the low end, so every query runs
  // over all four dimensions with the same hardware
  always_comb begin
    nd_eff = (num_dims_q > NDIMS_W'(MAX_DIMS)) ? NDIMS_W'(MAX_DIMS) : num_dims_q;
    for (int i = 0; i < MAX_DIMS; i++) begin
      eff[i] = (NDIMS_W'(i) < nd_eff) ? clamp_size(dim_size_q[i]) : SIZE_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // query capture
  // ---------------------------------------------------------------------------
  logic [MAX_DIMS-1:0][RANK_W-1:0] cin;
  ctx_t                            ctx_in;
  logic [RANK_W-1:0]               rank_src_q;
  ctx_t                            ctx_q [CHAIN_LEN+1];
  ctx_t                            ctx_n [CHAIN_LEN];

  assign cin = {coord_in_3, coord_in_2, coord_in_1, coord_in_0};

  always_comb begin
    ctx_in           = '0;
    ctx_in.valid     = start && !busy;
    ctx_in.op        = op_t'(operation);
    ctx_in.shift_dim = shift_dim;
    ctx_in.disp      = displacement;
    for (int i = 0; i < MAX_DIMS; i++) begin
      // magnitude of the coordinate, the divider works unsigned
      ctx_in.mag[i] = cin[i][RANK_W-1] ? (RANK_W'(0) - cin[i]) : cin[i];
      ctx_in.neg[i] = (ctx_in.op == OP_RANK_OF_COORDS) && cin[i][RANK_W-1];
      // out of range in a non-wrapping dimension in use
      if ((NDIMS_W'(i) < nd_eff) && !periodic_q[i] &&
          (cin[i][RANK_W-1] || cin[i] >= RANK_W'(eff[i]))) begin
        ctx_in.bad_coord = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rank_src_q <= (op_t'(operation) == OP_SHIFT) ? own_rank_q : rank_in;
  end

  // ---------------------------------------------------------------------------
  // division chain: divider k peels off dimension MAX_DIMS-1-k, least
  // significant first; coordinate queries reuse it to reduce each coordinate
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0]  quot_bus  [MAX_DIMS+1];
  logic [COORD_W-1:0] rem_bus   [MAX_DIMS];
  logic [RANK_W-1:0]  div_dvd   [MAX_DIMS];
  logic [SIZE_W-1:0]  div_dvs   [MAX_DIMS];
  logic [RANK_W-1:0]  disp_mag;
  logic [RANK_W-1:0]  disp_quot;
  logic [COORD_W-1:0] disp_rem;

  assign quot_bus[0] = rank_src_q;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_div
    localparam int DIM = MAX_DIMS - 1 - k;
    assign div_dvs[k] = eff[DIM];
    assign div_dvd[k] = (ctx_q[k*DIV_STAGES].op == OP_RANK_OF_COORDS) ?
                        ctx_q[k*DIV_STAGES].mag[DIM] : quot_bus[k];
    cgrm_divider u_div (
      .clk       (clk),
      .dividend  (div_dvd[k]),
      .divisor   (div_dvs[k]),
      .quotient  (quot_bus[k+1]),
      .remainder (rem_bus[k])
    );
  end

  // displacement residue along the shift dimension, beside the first divider
  assign disp_mag = ctx_q[0].disp[RANK_W-1] ? (RANK_W'(0) - ctx_q[0].disp) : ctx_q[0].disp;

  cgrm_divider u_div_disp (
    .clk       (clk),
    .dividend  (disp_mag),
    .divisor   (eff[ctx_q[0].shift_dim]),
    .quotient  (disp_quot),
    .remainder (disp_rem)
  );

  always_comb begin
    for (int j = 0; j < CHAIN_LEN; j++) ctx_n[j] = ctx_q[j];
    // residues land in the context as each divider finishes
    for (int k = 1; k < MAX_DIMS; k++) begin
      ctx_n[k*DIV_STAGES].res[MAX_DIMS-k] =
        wrap_res(rem_bus[k-1], ctx_q[k*DIV_STAGES].neg[MAX_DIMS-k], eff[MAX_DIMS-k]);
    end
    ctx_n[DIV_STAGES].disp_res =
      wrap_res(disp_rem, ctx_q[DIV_STAGES].disp[RANK_W-1], eff[ctx_q[DIV_STAGES].shift_dim]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= CHAIN_LEN; j++) ctx_q[j].valid <= 1'b0;
    end else begin
      ctx_q[0] <= ctx_in;
      for (int j = 0; j < CHAIN_LEN; j++) ctx_q[j+1] <= ctx_n[j];
    end
  end

  // ---------------------------------------------------------------------------
  // status and neighbour coordinates
  // ---------------------------------------------------------------------------
  ctx_t                  cx;
  coord_vec_t            crd;
  coord_vec_t            lane_a;
  coord_vec_t            lane_b;
  post_t                 post_in;
  logic [DIM_IDX_W-1:0]  sd;
  logic [COORD_W-1:0]    home;
  logic [SIZE_W-1:0]     esz;
  logic [SIZE_W-1:0]     dst_sum;
  logic [SIZE_W-1:0]     src_sum;
  logic signed [33:0]    dst_v;
  logic signed [33:0]    src_v;
  logic [COORD_W-1:0]    dst_c;
  logic [COORD_W-1:0]    src_c;
  logic                  dst_none_c;
  logic                  src_none_c;

  always_comb begin
    cx     = ctx_q[CHAIN_LEN];
    crd    = cx.res;
    crd[0] = wrap_res(rem_bus[MAX_DIMS-1], cx.neg[0], eff[0]);
    sd     = cx.shift_dim;
    home   = crd[sd];
    esz    = eff[sd];

    // wrapping move: home plus or minus the displacement residue
    dst_sum = {1'b0, home} + {1'b0, cx.disp_res};
    if (dst_sum >= esz) dst_sum = dst_sum - esz;
    if (home >= cx.disp_res) src_sum = {1'b0, home} - {1'b0, cx.disp_res};
    else                     src_sum = {1'b0, home} + esz - {1'b0, cx.disp_res};

    // non-wrapping move: exact position, none when it leaves the grid
    dst_v = $signed({26'd0, home}) + $signed({{2{cx.disp[RANK_W-1]}}, cx.disp});
    src_v = $signed({26'd0, home}) - $signed({{2{cx.disp[RANK_W-1]}}, cx.disp});

    if (periodic_q[sd]) begin
      dst_c      = dst_sum[COORD_W-1:0];
      src_c      = src_sum[COORD_W-1:0];
      dst_none_c = 1'b0;
      src_none_c = 1'b0;
    end else begin
      dst_c      = dst_v[COORD_W-1:0];
      src_c      = src_v[COORD_W-1:0];
      dst_none_c = dst_v[33] || (dst_v >= $signed({25'd0, esz}));
      src_none_c = src_v[33] || (src_v >= $signed({25'd0, esz}));
    end

    lane_a = crd;
    lane_b = crd;
    if (cx.op == OP_SHIFT) begin
      lane_a[sd] = dst_c;
      lane_b[sd] = src_c;
    end

    post_in          = '0;
    post_in.valid    = cx.valid;
    post_in.op       = cx.op;
    post_in.src_none = src_none_c;
    post_in.dst_none = dst_none_c;
    post_in.coords   = crd;
    // any quotient left over after the last dimension means rank >= node count
    case (cx.op)
      OP_RANK_OF_COORDS: post_in.status = cx.bad_coord ? ST_BAD_ARG : ST_OK;
      OP_COORDS_OF_RANK: post_in.status = (quot_bus[MAX_DIMS] != '0) ? ST_BAD_ARG : ST_OK;
      OP_SHIFT: begin
        if (nd_eff == '0)                          post_in.status = ST_BAD_ARG;
        else if (NDIMS_W'(sd) >= nd_eff)           post_in.status = ST_BAD_DIM;
        else if (quot_bus[MAX_DIMS] != '0)         post_in.status = ST_BAD_ARG;
        else                                       post_in.status = ST_OK;
      end
      default: post_in.status = ST_BAD_ARG;
    endcase
  end

  post_t      post_q [COMP_LAT+1];
  coord_vec_t lane_a_q;
  coord_vec_t lane_b_q;

  always_ff @(posedge clk) begin
    lane_a_q <= lane_a;
    lane_b_q <= lane_b;
    if (rst) begin
      for (int j = 0; j <= COMP_LAT; j++) post_q[j].valid <= 1'b0;
    end else begin
      post_q[0] <= post_in;
      for (int j = 1; j <= COMP_LAT; j++) post_q[j] <= post_q[j-1];
    end
  end

  // ---------------------------------------------------------------------------
  // composition: lane a gives the rank or the destination, lane b the source
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0] rank_a;
  logic [RANK_W-1:0] rank_b;

  cgrm_compose u_comp_a (
    .clk    (clk),
    .coords (lane_a_q),
    .sizes  (eff),
    .rank   (rank_a)
  );

  cgrm_compose u_comp_b (
    .clk    (clk),
    .coords (lane_b_q),
    .sizes  (eff),
    .rank   (rank_b)
  );

  // ---------------------------------------------------------------------------
  // result register: fields an operation does not produce stay zero
  // ---------------------------------------------------------------------------
  post_t pf;
  logic  ok;

  assign pf = post_q[COMP_LAT];
  assign ok = (pf.status == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pf.valid;
    end
    status      <= pf.status;
    rank_out    <= (ok && pf.op == OP_RANK_OF_COORDS) ? rank_a : '0;
    coord_out_0 <= (ok && pf.op == OP_COORDS_OF_RANK) ? pf.coords[0] : '0;
    coord_out_1 <= (ok && pf.op == OP_COORDS_OF_RANK) ? pf.coords[1] : '0;
    coord_out_2 <= (ok && pf.op == OP_COORDS_OF_RANK) ? pf.coords[2] : '0;
    coord_out_3 <= (ok && pf.op == OP_COORDS_OF_RANK) ? pf.coords[3] : '0;
    dest_rank   <= (ok && pf.op == OP_SHIFT && !pf.dst_none) ? rank_a : '0;
    source_rank <= (ok && pf.op == OP_SHIFT && !pf.src_none) ? rank_b : '0;
    dest_none   <= ok && pf.op == OP_SHIFT && pf.dst_none;
    source_none <= ok && pf.op == OP_SHIFT && pf.src_none;
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("query beat without its result beat");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |->
      (rank_out == '0 && dest_rank == '0 && source_rank == '0 && !dest_none && !source_none))
    else $error("failed query carries result data");

  a_none_rank: assert property (@(posedge clk) disable iff (rst)
    (done && (dest_none || source_none)) |->
      (status == ST_OK && (!dest_none || dest_rank == '0) && (!source_none || source_rank == '0)))
    else $error("missing neighbour with a rank");

endmodule

[dv/cartesian_grid_rank_mapper_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartesian_grid_rank_mapper_core_tb
// self-checking bench for the cartesian grid rank mapper
// ----------------------------------------------------------------------------
// a queue of pending beats (queries and register writes) feeds a driver on the
// falling edge; every accepted query is run through a local grid model and the
// expected result is queued; a monitor on the rising edge compares each done
// beat with the oldest expectation. register writes are only issued once the
// pipeline has drained. phases cycle through several grid settings, extremes
// included, and several sender gap rates.
// ----------------------------------------------------------------------------
module cartesian_grid_rank_mapper_core_tb import cgrm_pkg::*; ();

  localparam int  PIPE_LAT = 21;
  localparam int  SETTLE   = PIPE_LAT + 8;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]        op;
    logic [31:0]       rank_in;
    logic [3:0][31:0]  coord;
    logic [1:0]        shift_dim;
    logic [31:0]       disp;
  } grid_query_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      rank_out;
    logic [3:0][7:0]  coord;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic             src_none;
    logic             dst_none;
  } grid_res_t;

  // one pending beat: either a query or a register write
  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_val;
    logic [6:0]  gap_pct;
    grid_query_t q;
  } beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = '0;
  logic [31:0] rank_in = '0;
  logic signed [31:0] coord_in_0 = '0, coord_in_1 = '0, coord_in_2 = '0, coord_in_3 = '0;
  logic [1:0] shift_dim = '0;
  logic signed [31:0] displacement = '0;
  logic done;
  logic [1:0] status;
  logic [31:0] rank_out, source_rank, dest_rank;
  logic [7:0] coord_out_0, coord_out_1, coord_out_2, coord_out_3;
  logic source_none, dest_none;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #5 clk = ~clk;

  cartesian_grid_rank_mapper_core uut (.*);

  // grid settings as the block holds them (raw register values)
  logic [2:0]       grid_ndims = '0;
  logic [3:0][8:0]  grid_size  = {4{9'd1}};
  logic [3:0]       grid_wrap  = '0;
  logic [31:0]      grid_own   = '0;

  beat_t       pending_beats[$];
  grid_res_t   expected_results[$];
  int          mismatch_cnt = 0;
  longint      cycle_cnt = 0;
  int          quiet_cycles = 0;
  logic        query_took = 1'b0;
  logic        cfg_took = 1'b0;

  // ---------------------------------------------------------------- grid model
  function automatic longint eff_size(logic [8:0] raw);
    if (raw == 0) return 1;
    if (raw > 256) return 256;
    return raw;
  endfunction

  function automatic int dims_in_use(logic [2:0] raw);
    return (raw > 4) ? 4 : int'(raw);
  endfunction

  function automatic longint grid_nodes(int nd);
    longint n;
    n = 1;
    for (int i = 0; i < nd; i++) n = n * eff_size(grid_size[i]);
    return n;
  endfunction

  // in-range coordinate, wrapped where periodic; -1 when rejected
  function automatic longint fold_coord(int d, longint c);
    longint s;
    s = eff_size(grid_size[d]);
    if (c >= 0 && c < s) return c;
    if (!grid_wrap[d]) return -1;
    c = c % s;
    if (c < 0) c = c + s;
    return c;
  endfunction

  function automatic longint grid_rank(int nd, logic [3:0][8:0] pos);
    longint r, mul;
    r = 0;
    mul = 1;
    for (int i = nd - 1; i >= 0; i--) begin
      r = r + mul * longint'(pos[i]);
      mul = mul * eff_size(grid_size[i]);
    end
    return r;
  endfunction

  function automatic logic [3:0][8:0] grid_coords(int nd, longint rank);
    logic [3:0][8:0] pos;
    longint n;
    pos = '0;
    n = grid_nodes(nd);
    for (int i = 0; i < nd; i++) begin
      n = n / eff_size(grid_size[i]);
      pos[i] = 9'(rank / n);
      rank = rank % n;
    end
    return pos;
  endfunction

  function automatic grid_res_t map_query(grid_query_t q);
    grid_res_t r;
    logic [3:0][8:0] pos;
    longint c, rr, home, me;
    int nd, d;
    r = '0;
    pos = '0;
    nd = dims_in_use(grid_ndims);
    case (op_t'(q.op))
      OP_RANK_OF_COORDS: begin
        for (int i = 0; i < nd; i++) begin
          c = fold_coord(i, longint'($signed(q.coord[i])));
          if (c < 0) begin
            r.status = ST_BAD_ARG;
            return r;
          end
          pos[i] = 9'(c);
        end
        rr = grid_rank(nd, pos);
        if (rr > 64'hFFFF_FFFF) begin
          r.status = ST_BAD_ARG;
          return r;
        end
        r.rank_out = rr[31:0];
      end
      OP_COORDS_OF_RANK: begin
        if (longint'(q.rank_in) >= grid_nodes(nd)) begin
          r.status = ST_BAD_ARG;
          return r;
        end
        pos = grid_coords(nd, longint'(q.rank_in));
        for (int i = 0; i < nd; i++) r.coord[i] = pos[i][7:0];
      end
      OP_SHIFT: begin
        d = int'(q.shift_dim);
        me = longint'(grid_own);
        if (nd == 0) r.status = ST_BAD_ARG;
        else if (d >= nd) r.status = ST_BAD_DIM;
        else if (me >= grid_nodes(nd)) r.status = ST_BAD_ARG;
        if (r.status != ST_OK) return r;
        pos = grid_coords(nd, me);
        home = longint'(pos[d]);
        c = fold_coord(d, home + longint'($signed(q.disp)));
        if (c >= 0) begin
          pos[d] = 9'(c);
          r.dst = 32'(grid_rank(nd, pos));
        end else begin
          r.dst_none = 1'b1;
        end
        c = fold_coord(d, home - longint'($signed(q.disp)));
        if (c >= 0) begin
          pos[d] = 9'(c);
          r.src = 32'(grid_rank(nd, pos));
        end else begin
          r.src_none = 1'b1;
        end
      end
      default: r.status = ST_BAD_ARG;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  // a query stays on the bus until it is taken; a register write waits for an
  // empty pipeline plus the full latency
  always @(negedge clk) begin
    logic       nxt_start, nxt_cfg;
    beat_t      b;
    nxt_start = start && !query_took;
    nxt_cfg   = cfg_valid && !cfg_took;
    if (!rst && !nxt_start && !nxt_cfg && pending_beats.size() != 0) begin
      b = pending_beats[0];
      if (b.is_cfg) begin
        if (expected_results.size() == 0 && quiet_cycles > SETTLE) begin
          void'(pending_beats.pop_front());
          cfg_index <= b.cfg_idx;
          cfg_data  <= b.cfg_val;
          nxt_cfg = 1'b1;
        end
      end else if ($urandom_range(99) >= b.gap_pct) begin
        void'(pending_beats.pop_front());
        operation    <= b.q.op;
        rank_in      <= b.q.rank_in;
        coord_in_0   <= b.q.coord[0];
        coord_in_1   <= b.q.coord[1];
        coord_in_2   <= b.q.coord[2];
        coord_in_3   <= b.q.coord[3];
        shift_dim    <= b.q.shift_dim;
        displacement <= b.q.disp;
        nxt_start = 1'b1;
      end
    end
    start     <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    grid_res_t got, want;
    grid_query_t q;
    cycle_cnt <= cycle_cnt + 1;
    query_took <= start && !busy && !rst;
    cfg_took   <= cfg_valid && cfg_ready && !rst;
    if (!rst && start && !busy) begin
      q = '{operation, rank_in, {coord_in_3, coord_in_2, coord_in_1, coord_in_0},
            shift_dim, displacement};
      expected_results = {expected_results, map_query(q)};
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_NUM_DIMS:   grid_ndims = cfg_data[2:0];
        REG_DIM_SIZE_0: grid_size[0] = cfg_data[8:0];
        REG_DIM_SIZE_1: grid_size[1] = cfg_data[8:0];
        REG_DIM_SIZE_2: grid_size[2] = cfg_data[8:0];
        REG_DIM_SIZE_3: grid_size[3] = cfg_data[8:0];
        REG_PERIODIC:   grid_wrap = cfg_data[3:0];
        REG_OWN_RANK:   grid_own = cfg_data;
        default: ;
      endcase
    end
    if (!rst && done) begin
      got = '{status, rank_out, {coord_out_3, coord_out_2, coord_out_1, coord_out_0},
              source_rank, dest_rank, source_none, dest_none};
      if (expected_results.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected result beat: %p", got);
      end else begin
        want = expected_results.pop_front();
        // field by field, every field including the ones that must be zero
        if (got.status != want.status || got.rank_out != want.rank_out ||
            got.coord != want.coord || got.src != want.src || got.dst != want.dst ||
            got.src_none != want.src_none || got.dst_none != want.dst_none) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) begin
            $display("result mismatch");
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic add_reg(logic [2:0] idx, logic [31:0] val);
    beat_t b;
    b = '0;
    b.is_cfg = 1'b1;
    b.cfg_idx = idx;
    b.cfg_val = val;
    pending_beats = {pending_beats, b};
  endtask

  task automatic add_query(logic [1:0] op, logic [31:0] rk, logic [3:0][31:0] co,
                           logic [1:0] sd, logic [31:0] dp, int gap);
    beat_t b;
    b = '0;
    b.gap_pct = 7'(gap);
    b.q = '{op, rk, co, sd, dp};
    pending_beats = {pending_beats, b};
  endtask

  // whole register set; own rank kept mostly inside the grid
  task automatic add_grid(logic [2:0] nd, logic [3:0][8:0] sz, logic [3:0] per,
                          logic [31:0] own);
    add_reg(REG_NUM_DIMS, 32'(nd));
    add_reg(REG_DIM_SIZE_0, 32'(sz[0]));
    add_reg(REG_DIM_SIZE_1, 32'(sz[1]));
    add_reg(REG_DIM_SIZE_2, 32'(sz[2]));
    add_reg(REG_DIM_SIZE_3, 32'(sz[3]));
    add_reg(REG_PERIODIC, 32'(per));
    add_reg(REG_OWN_RANK, own);
  endtask

  function automatic logic [31:0] pick_wide();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // coordinate mostly inside the dimension, sometimes in -2s..2s, occasionally anywhere
  function automatic logic [31:0] pick_coord(longint s);
    longint v;
    if ($urandom_range(9) == 0) return pick_wide();
    if ($urandom_range(3) == 0) v = longint'($urandom_range(4 * s)) - 2 * s;
    else v = longint'($urandom_range(s - 1));
    return 32'(v);
  endfunction

  initial begin
    logic [3:0][8:0]  sz;
    logic [3:0][31:0] co;
    logic [2:0]       nd;
    logic [3:0]       per;
    longint           nodes, s;
    int               gap, ndu;
    int               gap_rates[4] = '{0, 73, 0, 27};

    // directed: full 256^4 grid, all periodic, then none periodic
    for (int p = 0; p < 2; p++) begin
      add_grid(3'd4, {4{9'd256}}, p ? 4'h0 : 4'hF, p ? 32'hFFFF_FFFF : 32'h0101_0101);
      add_query(OP_RANK_OF_COORDS, 0, {4{32'd0}}, 0, 0, 0);
      add_query(OP_RANK_OF_COORDS, 0, {4{32'd255}}, 0, 0, 0);
      add_query(OP_RANK_OF_COORDS, 0, {32'd256, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000}, 0, 0, 0);
      add_query(OP_COORDS_OF_RANK, 32'hFFFF_FFFF, '0, 0, 0, 0);
      add_query(OP_COORDS_OF_RANK, 32'd0, '0, 0, 0, 0);
      add_query(OP_COORDS_OF_RANK, 32'h0123_4567, '0, 0, 0, 0);
      for (int d = 0; d < 4; d++) begin
        add_query(OP_SHIFT, 0, '0, 2'(d), 32'd1, 0);
        add_query(OP_SHIFT, 0, '0, 2'(d), (d % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, 0);
      end
      add_query(OP_SHIFT, 0, '0, 2'd1, 32'hFFFF_FFFF, 0);
      add_query(OP_RESERVED, 32'hFFFF_FFFF, {4{32'hFFFF_FFFF}}, 2'd3, 32'hFFFF_FFFF, 0);
    end
    // no grid: only rank 0 maps, a shift is refused
    add_grid(3'd0, {4{9'd0}}, 4'h0, 32'd0);
    add_query(OP_COORDS_OF_RANK, 32'd0, '0, 0, 0, 0);
    add_query(OP_COORDS_OF_RANK, 32'd1, '0, 0, 0, 0);
    add_query(OP_SHIFT, 0, '0, 2'd0, 32'd1, 0);
    add_query(OP_RANK_OF_COORDS, 0, {4{32'hDEAD_BEEF}}, 0, 0, 0);
    // too many dimensions, sizes zero and oversized, direction past the grid
    add_grid(3'd7, {9'd511, 9'd0, 9'd257, 9'd3}, 4'hA, 32'd5);
    add_query(OP_SHIFT, 0, '0, 2'd3, 32'd2, 0);
    add_query(OP_RANK_OF_COORDS, 0, {32'd4, 32'd1, 32'd0, 32'd300}, 0, 0, 0);
    add_grid(3'd2, {9'd3, 9'd4, 9'd5, 9'd6}, 4'h1, 32'd11);
    add_query(OP_SHIFT, 0, '0, 2'd2, 32'd1, 0);
    add_query(OP_SHIFT, 0, '0, 2'd1, 32'd3, 0);

    // random phases: new grid, then a batch of queries at one gap rate
    for (int ph = 0; ph < 16; ph++) begin
      gap = gap_rates[ph % 4];
      nd = (ph % 5 == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4));
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(7))
          0: sz[i] = 9'd0;
          1: sz[i] = 9'($urandom_range(257, 511));
          2: sz[i] = 9'd256;
          3: sz[i] = 9'd1;
          default: sz[i] = 9'($urandom_range(2, 12));
        endcase
      end
      per = 4'($urandom);
      ndu = (nd > 4) ? 4 : int'(nd);
      nodes = 1;
      for (int i = 0; i < ndu; i++) nodes = nodes * eff_size(sz[i]);
      add_grid(nd, sz, per, ($urandom_range(5) == 0) ? pick_wide()
               : 32'($urandom_range(32'(nodes - 1))));
      for (int k = 0; k < 95; k++) begin
        for (int i = 0; i < 4; i++) begin
          s = eff_size(sz[i]);
          co[i] = pick_coord(s);
        end
        add_query($urandom_range(15) == 0 ? OP_RESERVED : 2'($urandom_range(2)),
                  ($urandom_range(7) == 0) ? pick_wide()
                    : 32'($urandom_range(32'((nodes + nodes / 8 > 64'hFFFF_FFFF)
                        ? 64'hFFFF_FFFF : nodes + nodes / 8))),
                  co, 2'($urandom_range(3)),
                  ($urandom_range(7) == 0) ? pick_wide()
                    : 32'(longint'($urandom_range(40)) - 20), gap);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || start || cfg_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
